// ===== rtl/duri_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Data-URI payload decoder package
// Shared types, character codes and lookup functions for the percent and
// base64 decoding paths.
// ----------------------------------------------------------------------------
package duri_pkg;

    // Result queue depth and count width (count holds 0..QDepth)
    localparam int QDepth = 4;
    localparam int QCntW  = $clog2(QDepth + 1);

    // Most results one character can produce
    localparam int MaxRes = 3;

    // Character codes
    localparam logic [7:0] ChPercent = 8'h25;
    localparam logic [7:0] ChEqual   = 8'h3d;
    localparam logic [7:0] ChSpace   = 8'h20;
    localparam logic [7:0] ChTab     = 8'h09;
    localparam logic [7:0] ChLf      = 8'h0a;
    localparam logic [7:0] ChCr      = 8'h0d;
    localparam logic [7:0] ChPlus    = 8'h2b;
    localparam logic [7:0] ChSlash   = 8'h2f;

    // Base64 sextet values
    localparam logic [5:0] B64Plus  = 6'd62;
    localparam logic [5:0] B64Slash = 6'd63;
    localparam logic [7:0] B64LowerOfs = 8'd71;   // 'a' maps to 26
    localparam logic [7:0] B64UpperOfs = 8'd65;   // 'A' maps to 0
    localparam logic [7:0] B64DigitOfs = 8'd4;    // '0' maps to 52

    // Decode mode register values
    localparam logic ModePercent = 1'b0;
    localparam logic ModeBase64  = 1'b1;

    // Percent escape progress
    typedef enum logic [1:0] {
        PendNone = 2'd0,
        PendPct  = 2'd1,
        PendHex  = 2'd2
    } pend_t;

    // Base64 phase: bits short of a full byte are 8 - 2*phase
    localparam logic [1:0] PhaseShort8  = 2'd0;
    localparam logic [1:0] PhaseShort10 = 2'd3;

    // One result beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       decode_error;
        logic       stream_end;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } b64_t;

    // Hex digit value, either case
    function automatic hex_t hex_of(input logic [7:0] c);
        hex_t r;
        r = '0;
        if (c >= "0" && c <= "9")
        begin
            r.ok  = 1'b1;
            r.val = c[3:0];
        end
        else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
        begin
            r.ok  = 1'b1;
            r.val = c[3:0] + 4'd9;
        end
        return r;
    endfunction

    // Standard base64 alphabet value
    function automatic b64_t b64_of(input logic [7:0] c);
        b64_t       r;
        logic [7:0] v;
        r = '0;
        v = '0;
        if (c >= "A" && c <= "Z")
        begin
            v = c - B64UpperOfs;
            r.ok = 1'b1;
            r.val = v[5:0];
        end
        else if (c >= "a" && c <= "z")
        begin
            v = c - B64LowerOfs;
            r.ok = 1'b1;
            r.val = v[5:0];
        end
        else if (c >= "0" && c <= "9")
        begin
            v = c + B64DigitOfs;
            r.ok = 1'b1;
            r.val = v[5:0];
        end
        else if (c == ChPlus)
        begin
            r.ok = 1'b1;
            r.val = B64Plus;
        end
        else if (c == ChSlash)
        begin
            r.ok = 1'b1;
            r.val = B64Slash;
        end
        return r;
    endfunction

endpackage

// ===== rtl/data_uri_payload_decoder_unit.sv =====
`timescale 1ns / 1ps
// A character's result beats are registered into the queue behind any waiting beats.
// Throughput: one character per cycle while each yields at most one result and the
//   output is not stalled; a character with two or three results stalls the input.
// The input is ready while the four-entry result queue holds at most one beat.
// Reset clears the decode state, empties the queue and selects percent mode.
// ----------------------------------------------------------------------------
// Data-URI payload decoder
// Decodes one payload character per beat in percent or base64 mode and
// queues up to three result beats per character.
// ----------------------------------------------------------------------------
module data_uri_payload_decoder_unit
(
    input  logic       clk,
    input  logic       rst_n,
    // Mode register write
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,      // decode_mode
    // Character input
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,     // [7:0] char_code
    input  logic       s_axis_tlast,     // is_last
    // Result output
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,     // [7:0] data_byte
    output logic [1:0] m_axis_tuser,     // [0] byte_valid, [1] decode_error
    output logic       m_axis_tlast      // stream_end
);

    localparam int QD = duri_pkg::QDepth;
    localparam int CW = duri_pkg::QCntW;

    // State
    logic             mode_reg;
    duri_pkg::pend_t  pend_reg, pend_next;
    logic [7:0]       held_reg, held_next;
    logic [11:0]      acc_reg, acc_next;
    logic [1:0]       phase_reg, phase_next;
    logic             pad_reg, pad_next;
    logic             err_reg, err_next;

    // Result queue: head always at entry 0
    duri_pkg::result_t q_reg  [QD];
    duri_pkg::result_t q_next [QD];
    logic [CW-1:0]     cnt_reg, cnt_next;

    // Decode outputs
    duri_pkg::result_t res [duri_pkg::MaxRes];
    logic [1:0]        res_n;

    logic          accept;
    logic          pop;
    logic [1:0]    push_n;
    logic [CW-1:0] base;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign pop    = m_axis_tvalid && m_axis_tready;

    // Decode one character against the current state
    always_comb
    begin
        logic [7:0]      c;
        logic            last;
        duri_pkg::hex_t  hc;
        duri_pkg::hex_t  hh;
        duri_pkg::b64_t  bc;
        logic [11:0]     acc_sh;
        logic            fresh;
        logic [1:0]      pre_n;
        logic [7:0]      pre0;
        logic [7:0]      b0;
        logic [7:0]      b1;
        logic [7:0]      b2;
        logic [1:0]      n;

        c      = s_axis_tdata;
        last   = s_axis_tlast;
        hc     = duri_pkg::hex_of(c);
        hh     = duri_pkg::hex_of(held_reg);
        bc     = duri_pkg::b64_of(c);
        acc_sh = {acc_reg[5:0], bc.val};

        pend_next  = pend_reg;
        held_next  = held_reg;
        acc_next   = acc_reg;
        phase_next = phase_reg;
        pad_next   = pad_reg;
        err_next   = err_reg;
        fresh      = 1'b0;
        pre_n      = 2'd0;
        pre0       = duri_pkg::ChPercent;
        b0         = c;
        b1         = c;
        b2         = c;
        n          = 2'd0;

        if (mode_reg == duri_pkg::ModePercent)
        begin
            // Resolve any held escape
            case (pend_reg)
                duri_pkg::PendPct:
                begin
                    if (hc.ok && !last)
                    begin
                        held_next = c;
                        pend_next = duri_pkg::PendHex;
                    end
                    else
                    begin
                        pend_next = duri_pkg::PendNone;
                        pre_n     = 2'd1;
                        fresh     = 1'b1;
                    end
                end
                duri_pkg::PendHex:
                begin
                    pend_next = duri_pkg::PendNone;
                    if (hc.ok)
                    begin
                        pre_n = 2'd1;
                        pre0  = {(hh.ok ? hh.val : 4'd0), hc.val};
                    end
                    else
                    begin
                        pre_n = 2'd2;
                        fresh = 1'b1;
                    end
                end
                default:
                begin
                    pend_next = duri_pkg::PendNone;
                    fresh     = 1'b1;
                end
            endcase

            // Place flushed bytes, then the character itself
            b0 = (pre_n == 2'd0) ? c : pre0;
            b1 = (pre_n == 2'd1) ? c : held_reg;
            b2 = c;
            n  = pre_n;
            if (fresh)
            begin
                if (c == duri_pkg::ChPercent && !last)
                    pend_next = duri_pkg::PendPct;
                else
                    n = pre_n + 2'd1;
            end
        end
        else
        begin
            // Base64: skip after padding or error
            if (!pad_reg && !err_reg)
            begin
                if (c == duri_pkg::ChEqual)
                    pad_next = 1'b1;
                else if (c == duri_pkg::ChSpace || c == duri_pkg::ChTab ||
                         c == duri_pkg::ChLf || c == duri_pkg::ChCr)
                    pad_next = pad_reg;
                else if (!bc.ok)
                    err_next = 1'b1;
                else
                begin
                    acc_next = acc_sh;
                    if (phase_reg == duri_pkg::PhaseShort8)
                        phase_next = duri_pkg::PhaseShort10;
                    else
                    begin
                        phase_next = phase_reg - 2'd1;
                        n          = 2'd1;
                        case (phase_reg)
                            2'd1:    b0 = acc_sh[7:0];
                            2'd2:    b0 = acc_sh[9:2];
                            default: b0 = acc_sh[11:4];
                        endcase
                    end
                end
            end
        end

        // Build result beats
        res[0] = '{data_byte: b0, byte_valid: (n != 2'd0), decode_error: 1'b0,
                   stream_end: 1'b0};
        res[1] = '{data_byte: b1, byte_valid: 1'b1, decode_error: 1'b0,
                   stream_end: 1'b0};
        res[2] = '{data_byte: b2, byte_valid: 1'b1, decode_error: 1'b0,
                   stream_end: 1'b0};
        res_n  = n;

        // Stream end: mark final beat, clear state
        if (last)
        begin
            if (n == 2'd0)
            begin
                res[0].data_byte = 8'd0;
                res_n = 2'd1;
            end
            res[res_n - 2'd1].decode_error = err_next;
            res[res_n - 2'd1].stream_end   = 1'b1;
            pend_next  = duri_pkg::PendNone;
            held_next  = 8'd0;
            acc_next   = 12'd0;
            phase_next = duri_pkg::PhaseShort8;
            pad_next   = 1'b0;
            err_next   = 1'b0;
        end
    end

    // Queue update: shift on pop, append new beats behind the survivors
    assign push_n   = accept ? res_n : 2'd0;
    assign base     = cnt_reg - {{(CW-1){1'b0}}, pop};
    assign cnt_next = base + {{(CW-2){1'b0}}, push_n};

    always_comb
    begin
        logic [CW-1:0] slot;
        slot = '0;
        for (int i = 0; i < QD; i++)
        begin
            if (pop && i < QD - 1)
                q_next[i] = q_reg[(i < QD - 1) ? i + 1 : i];
            else
                q_next[i] = q_reg[i];
            slot = CW'(i) - base;
            if (CW'(i) >= base && slot < {{(CW-2){1'b0}}, push_n})
                q_next[i] = res[slot[1:0]];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= duri_pkg::ModePercent;
            pend_reg  <= duri_pkg::PendNone;
            held_reg  <= 8'd0;
            acc_reg   <= 12'd0;
            phase_reg <= duri_pkg::PhaseShort8;
            pad_reg   <= 1'b0;
            err_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                mode_reg <= cfg_wr_data;
            if (accept)
            begin
                pend_reg  <= pend_next;
                held_reg  <= held_next;
                acc_reg   <= acc_next;
                phase_reg <= phase_next;
                pad_reg   <= pad_next;
                err_reg   <= err_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Queue payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QD; i++)
            q_reg[i] <= q_next[i];
    end

    // Ready while room for a full three-beat flush
    assign s_axis_tready = (cnt_reg < CW'(QD - duri_pkg::MaxRes + 1));

    assign m_axis_tvalid   = (cnt_reg != '0);
    assign m_axis_tdata    = q_reg[0].data_byte;
    assign m_axis_tuser[0] = q_reg[0].byte_valid;
    assign m_axis_tuser[1] = q_reg[0].decode_error;
    assign m_axis_tlast    = q_reg[0].stream_end;

endmodule

// ===== rtl/duri_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Data-URI payload decoder port checker
// Watches the result port of the decoder over time.
// ----------------------------------------------------------------------------
module duri_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [1:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    // Stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

    // Error flag only on the final beat of a stream
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("decode error shown before stream end");

    // An empty beat is only the stream-end marker with a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == 8'd0))
    else $error("empty beat that is not the stream end");

    // Queue comes out of reset empty
    assert property (@(posedge clk)
        !$past(rst_n) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind data_uri_payload_decoder_unit duri_checker u_duri_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/duri_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Data-URI decoder result checker
// Watches the mode write port and both stream channels, predicts the result
// beats of every accepted character and compares them in order with the
// beats the decoder delivers.
// ----------------------------------------------------------------------------
module duri_result_checker
    import duri_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,      // [7:0] char_code
    input  logic       s_tlast,      // is_last
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,      // [7:0] data_byte
    input  logic [1:0] m_tuser,      // [0] byte_valid, [1] decode_error
    input  logic       m_tlast,      // stream_end
    output int         mismatch_count,
    output int         beats_due
);

    // Decoder state as predicted
    logic        mode_sel;
    pend_t       pend_state;
    logic [7:0]  held_digit;
    logic [11:0] sextet_bits;
    logic [1:0]  sextet_phase;
    logic        pad_seen;
    logic        bad_seen;

    // Beats made by the character being decoded, and beats still awaited
    result_t     char_beats [0:MaxRes-1];
    int          char_beat_cnt;
    result_t     expected_beats [$];

    function automatic int hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c) - int'("0");
        if (c >= "a" && c <= "f")
            return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic int sextet_value(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
            return int'(c) - int'("A");
        if (c >= "a" && c <= "z")
            return int'(c) - int'("a") + 26;
        if (c >= "0" && c <= "9")
            return int'(c) - int'("0") + 52;
        if (c == ChPlus)
            return 62;
        if (c == ChSlash)
            return 63;
        return -1;
    endfunction

    task automatic add_beat(input logic [7:0] value);
        result_t r;
        r              = '0;
        r.data_byte    = value;
        r.byte_valid   = 1'b1;
        char_beats[char_beat_cnt] = r;
        char_beat_cnt++;
    endtask

    task automatic clear_stream();
        pend_state   = PendNone;
        held_digit   = '0;
        sextet_bits  = '0;
        sextet_phase = PhaseShort8;
        pad_seen     = 1'b0;
        bad_seen     = 1'b0;
    endtask

    // Character with no escape in progress
    task automatic plain_char(input logic [7:0] c, input logic last);
        if (c == ChPercent && !last)
            pend_state = PendPct;
        else
            add_beat(c);
    endtask

    task automatic percent_char(input logic [7:0] c, input logic last);
        int h;
        int hi;
        h = hex_value(c);
        if (pend_state == PendPct)
        begin
            if (h >= 0 && !last)
            begin
                held_digit = c;
                pend_state = PendHex;
            end
            else
            begin
                // Escape broken after the '%': emit it and reprocess
                pend_state = PendNone;
                add_beat(ChPercent);
                plain_char(c, last);
            end
        end
        else if (pend_state == PendHex)
        begin
            pend_state = PendNone;
            if (h >= 0)
            begin
                hi = hex_value(held_digit);
                if (hi < 0)
                    hi = 0;
                add_beat({hi[3:0], h[3:0]});
            end
            else
            begin
                // Escape broken after one digit: flush both held characters
                add_beat(ChPercent);
                add_beat(held_digit);
                plain_char(c, last);
            end
        end
        else
        begin
            pend_state = PendNone;
            plain_char(c, last);
        end
    endtask

    task automatic base64_char(input logic [7:0] c);
        int d;
        int sh;
        d = sextet_value(c);
        if (pad_seen || bad_seen)
            return;
        if (c == ChEqual)
            pad_seen = 1'b1;
        else if (c == ChSpace || c == ChTab || c == ChCr || c == ChLf)
            return;
        else if (d < 0)
            bad_seen = 1'b1;
        else
        begin
            sextet_bits = {sextet_bits[5:0], d[5:0]};
            if (sextet_phase == PhaseShort8)
                sextet_phase = PhaseShort10;
            else
            begin
                sh = 2 * int'(sextet_phase) - 2;
                add_beat(8'(sextet_bits >> sh));
                sextet_phase = sextet_phase - 2'd1;
            end
        end
    endtask

    // Predict the beats of one accepted character and queue them
    task automatic decode_char(input logic [7:0] c, input logic last);
        char_beat_cnt = 0;
        if (mode_sel == ModeBase64)
            base64_char(c);
        else
            percent_char(c, last);
        if (last)
        begin
            if (char_beat_cnt == 0)
            begin
                char_beats[0] = '0;
                char_beat_cnt = 1;
            end
            char_beats[char_beat_cnt - 1].decode_error = bad_seen;
            char_beats[char_beat_cnt - 1].stream_end   = 1'b1;
            clear_stream();
        end
        for (int i = 0; i < char_beat_cnt; i++)
            expected_beats = {expected_beats, char_beats[i]};
    endtask

    // Compare one delivered beat with the oldest expectation
    task automatic check_beat();
        result_t want;
        if (expected_beats.size() == 0)
        begin
            $error("unexpected result beat: data_byte %0h user %0b last %0b",
                   m_tdata, m_tuser, m_tlast);
            mismatch_count++;
            return;
        end
        want = expected_beats.pop_front();
        if (m_tdata != want.data_byte)
        begin
            $error("data_byte: expected %0h, got %0h", want.data_byte, m_tdata);
            mismatch_count++;
        end
        if (m_tuser[0] != want.byte_valid)
        begin
            $error("byte_valid: expected %0b, got %0b", want.byte_valid, m_tuser[0]);
            mismatch_count++;
        end
        if (m_tuser[1] != want.decode_error)
        begin
            $error("decode_error: expected %0b, got %0b", want.decode_error, m_tuser[1]);
            mismatch_count++;
        end
        if (m_tlast != want.stream_end)
        begin
            $error("stream_end: expected %0b, got %0b", want.stream_end, m_tlast);
            mismatch_count++;
        end
    endtask

    // Track the mode register, check output beats, predict input beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_sel = ModePercent;
            clear_stream();
            expected_beats.delete();
            mismatch_count = 0;
            beats_due      = 0;
        end
        else
        begin
            if (cfg_wr_en)
                mode_sel = cfg_wr_data;
            if (m_tvalid && m_tready)
                check_beat();
            if (s_tvalid && s_tready)
                decode_char(s_tdata, s_tlast);
            beats_due = expected_beats.size();
        end
    end

endmodule

// ===== tb/data_uri_payload_decoder_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Data-URI payload decoder testbench
// Drives directed and random character streams in both decode modes with
// random source gaps and sink stalls; a checker beside the decoder predicts
// and compares every result beat.
// ----------------------------------------------------------------------------
module data_uri_payload_decoder_unit_tb;
    import duri_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_wr_en;
    logic       cfg_wr_data;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic       m_axis_tlast;

    int         mismatch_count;
    int         beats_due;
    int         src_idle_pct;
    int         sink_idle_pct;
    int         random_chars;
    logic       cur_mode;

    string      hex_set    = "0123456789abcdefABCDEF";
    string      sextet_set =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    string      space_set  = " \t\r\n";

    data_uri_payload_decoder_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    duri_result_checker result_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_tvalid       (s_axis_tvalid),
        .s_tready       (s_axis_tready),
        .s_tdata        (s_axis_tdata),
        .s_tlast        (s_axis_tlast),
        .m_tvalid       (m_axis_tvalid),
        .m_tready       (m_axis_tready),
        .m_tdata        (m_axis_tdata),
        .m_tuser        (m_axis_tuser),
        .m_tlast        (m_axis_tlast),
        .mismatch_count (mismatch_count),
        .beats_due      (beats_due)
    );

    // Clock, 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Sink: stall at random
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Hard stop
    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Send one character beat, with random gaps ahead of it
    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_text(input string s, input logic last_at_end);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], last_at_end && (i == s.len() - 1));
    endtask

    // Write the mode once the decoder has drained
    task automatic set_mode(input logic m);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (beats_due != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cur_mode = m;
    endtask

    // Mostly escapes and hex digits, some plain and arbitrary bytes
    function automatic logic [7:0] percent_pick();
        int r;
        r = $urandom_range(99);
        if (r < 25)
            return ChPercent;
        if (r < 55)
            return hex_set[$urandom_range(21)];
        if (r < 85)
            return 8'($urandom_range(32, 126));
        return 8'($urandom_range(255));
    endfunction

    // Mostly alphabet characters, some whitespace, padding and junk
    function automatic logic [7:0] base64_pick();
        int r;
        r = $urandom_range(99);
        if (r < 78)
            return sextet_set[$urandom_range(63)];
        if (r < 88)
            return space_set[$urandom_range(3)];
        if (r < 92)
            return ChEqual;
        return 8'($urandom_range(255));
    endfunction

    initial
    begin
        int len;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = ModePercent;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        src_idle_pct  = 9;
        sink_idle_pct = 53;
        cur_mode      = ModePercent;
        random_chars  = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Percent: byte extremes, both hex cases, broken escapes
        set_mode(ModePercent);
        send_char(8'h00, 1'b0);
        send_char(8'hff, 1'b0);
        send_text("%fF%Ag%%aZ", 1'b1);
        // Lone '%' as the last character
        send_text("%", 1'b1);
        // Switch to base64 with a digit held, then whitespace, padding, ignored tail
        send_text("%4", 1'b0);
        set_mode(ModeBase64);
        send_text("TW\tE=x", 1'b1);
        // Top sextets, invalid character, ignored tail
        send_text("+/9z!A", 1'b1);

        // Random streams across the three idle phases
        while (random_chars < 125)
        begin
            if (random_chars < 42)
            begin
                src_idle_pct  = 9;
                sink_idle_pct = 53;
            end
            else if (random_chars < 84)
            begin
                src_idle_pct  = 53;
                sink_idle_pct = 9;
            end
            else
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            if ($urandom_range(99) < 30)
                set_mode(1'($urandom_range(1)));
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
            begin
                // Occasionally set a random mode in the middle of a stream
                if ($urandom_range(99) < 3)
                    set_mode(1'($urandom_range(1)));
                if (cur_mode == ModeBase64)
                    send_char(base64_pick(), i == len - 1);
                else
                    send_char(percent_pick(), i == len - 1);
                random_chars++;
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then wait on for stray beats
        @(posedge clk);
        while (beats_due != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatch_count == 0 && beats_due == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
